/* design/edge_loop_duplicate_detector_defines.svh */
// Assertion macros shared by the edge loop duplicate detector.
`ifndef EDGE_LOOP_DUPLICATE_DETECTOR_DEFINES_SVH
`define EDGE_LOOP_DUPLICATE_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define ELDD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define ELDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/eldd_pkg.sv */
// Package with the shared types and constants of the edge loop duplicate detector.
package eldd_pkg;

    // Width of one endpoint field on the input stream.
    localparam int NODE_IN_W   = 16;
    // Input tdata holds node_a then node_b.
    localparam int IN_TDATA_W  = 2 * NODE_IN_W;
    // Output tdata holds the three result flags, padded to one byte.
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 3;

    // Status handed from the key pipeline to the controller.
    typedef struct packed {
        logic valid;   // one-cycle pulse when a new key is ready
        logic loop;    // both endpoints are the same vertex
    } t_key_status;

endpackage

/* design/eldd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module eldd_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/eldd_key.sv */
// Three-stage pipeline that forms the order-free Cantor pairing key of an edge.
module eldd_key #(
    parameter int NODE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [eldd_pkg::NODE_IN_W-1:0] i_node_a,
    input  logic [eldd_pkg::NODE_IN_W-1:0] i_node_b,
    output eldd_pkg::t_key_status          o_status,
    output logic [2*((NODE_BITS < eldd_pkg::NODE_IN_W) ? NODE_BITS
                                                       : eldd_pkg::NODE_IN_W)+1:0] o_key
);

    import eldd_pkg::*;

    // Only the low NODE_BITS bits of each endpoint take part, at most NODE_IN_W bits.
    localparam int EFF_BITS = (NODE_BITS < NODE_IN_W) ? NODE_BITS : NODE_IN_W;
    localparam int SUM_W    = EFF_BITS + 1;
    localparam int PROD_W   = 2 * SUM_W;
    localparam int TRI_W    = PROD_W - 1;
    localparam int KEY_W    = 2 * EFF_BITS + 2;

    logic [EFF_BITS-1:0] node_a;
    logic [EFF_BITS-1:0] node_b;
    logic [SUM_W-1:0]    n_sum;
    logic [EFF_BITS-1:0] n_lo;

    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic [SUM_W-1:0]    r_sum;
    logic [EFF_BITS-1:0] r_lo1;
    logic [EFF_BITS-1:0] r_lo2;
    logic                r_loop;
    logic [PROD_W-1:0]   r_prod;
    logic [KEY_W-1:0]    r_key;

    // Endpoint sum and smaller endpoint.
    always_comb begin
        node_a = i_node_a[EFF_BITS-1:0];
        node_b = i_node_b[EFF_BITS-1:0];
        n_sum  = {1'b0, node_a} + {1'b0, node_b};
        n_lo   = (node_a < node_b) ? node_a : node_b;
    end

    // Valid pulses travel with the data; each stage loads only on its pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (i_start) begin
            r_sum  <= n_sum;
            r_lo1  <= n_lo;
            r_loop <= (node_a == node_b);
        end
        // s*(s+1) is always even, so halving it later is exact.
        if (r_v1) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(r_sum + SUM_W'(1));
            r_lo2  <= r_lo1;
        end
        if (r_v2) begin
            r_key <= KEY_W'(r_prod[PROD_W-1:1]) + KEY_W'(r_lo2);
        end
    end

    assign o_status.valid = r_v3;
    assign o_status.loop  = r_loop;
    assign o_key          = r_key;

    // TRI_W documents the triangular number width carried into the key.
    if (TRI_W + 1 != KEY_W) begin : g_width_check
        $error("key width does not match triangular width");
    end

endmodule

/* design/edge_loop_duplicate_detector.sv */
// Edge loop and duplicate detector: key pipeline, key store and search control.
//
// One undirected edge is taken per request on the s_axis channel (node_a and
// node_b in tdata, tlast marking the final edge of a graph). One result per
// edge leaves on the m_axis channel as three flags: self-loop, duplicate and
// dropped because the key store was full.
// Edges are handled one at a time. An edge passes the three key pipeline
// stages; when its key is ready the controller decides whether a search is
// needed, and a resolve step then registers the result and writes back a new key.
// When its key is not above the largest stored key, the store is searched
// with one memory read per cycle, over at most count stored keys, where
// count is the number of keys stored so far (at most TABLE_DEPTH).
// The input is ready again in the cycle after the result is registered, even
// while that result still waits on m_axis; a stalled receiver only holds the
// block once a second result is ready to be handed over.
// Reset empties the store at once by clearing the stored count and the
// largest key; the memory itself is not swept. The same clearing happens
// after an edge with tlast set has been handled.
`include "edge_loop_duplicate_detector_defines.svh"

module edge_loop_duplicate_detector #(
    parameter int NODE_BITS   = 16,
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input edge requests.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata fields from bit 0: node_a (16 bits), node_b (16 bits).
    input  logic [eldd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tlast,
    // Result requests.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata fields from bit 0: is_loop, is_duplicate, not_stored, zero padding.
    output logic [eldd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import eldd_pkg::*;

    localparam int EFF_BITS = (NODE_BITS < NODE_IN_W) ? NODE_BITS : NODE_IN_W;
    localparam int KEY_W    = 2 * EFF_BITS + 2;
    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_SEARCH,
        ST_RESOLVE
    } t_state;

    t_state           r_state;
    logic             r_last;
    logic             r_found;
    logic             r_pend;
    logic [CNT_W-1:0] r_issue_idx;
    logic [CNT_W-1:0] r_count;
    logic [KEY_W-1:0] r_largest;
    logic             r_out_valid;
    logic             r_out_loop;
    logic             r_out_dup;
    logic             r_out_drop;

    t_key_status      key_status;
    logic [KEY_W-1:0] key;
    logic             in_accept;
    logic             rd_en;
    logic [KEY_W-1:0] rd_data;
    logic             hit;
    logic             issue_done;
    logic             out_free;
    logic             is_new;
    logic             wr_en;
    logic             n_dup;
    logic             n_drop;

    // Key pipeline.
    eldd_key #(
        .NODE_BITS (NODE_BITS)
    ) u_key (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_node_a (s_axis_tdata[NODE_IN_W-1:0]),
        .i_node_b (s_axis_tdata[IN_TDATA_W-1:NODE_IN_W]),
        .o_status (key_status),
        .o_key    (key)
    );

    // Store of seen keys; new keys are appended at the stored count.
    eldd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (key),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Search and write-back decisions. Reads and writes never overlap because
    // only one edge is in the store logic at a time.
    always_comb begin
        in_accept  = s_axis_tvalid && s_axis_tready;
        hit        = r_pend && (rd_data == key);
        issue_done = (r_issue_idx == r_count);
        rd_en      = (r_state == ST_SEARCH) && !issue_done && !hit;
        out_free   = !r_out_valid || m_axis_tready;
        is_new     = !key_status.loop && !r_found;
        wr_en      = (r_state == ST_RESOLVE) && out_free && is_new && (r_count != DEPTH_C);
        n_dup      = !key_status.loop && r_found;
        n_drop     = is_new && (r_count == DEPTH_C);
    end

    // Controller state, store bookkeeping and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_largest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= rd_en;
            // The result register fills on a resolve and empties when taken.
            if ((r_state == ST_RESOLVE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_last  <= s_axis_tlast;
                        r_state <= ST_KEY;
                    end
                end
                ST_KEY: begin
                    if (key_status.valid) begin
                        r_found     <= 1'b0;
                        r_issue_idx <= '0;
                        // A loop, a key above the maximum or an empty store needs no search.
                        if (key_status.loop || (key > r_largest) || (r_count == '0)) begin
                            r_state <= ST_RESOLVE;
                        end else begin
                            r_state <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (rd_en) begin
                        r_issue_idx <= r_issue_idx + CNT_W'(1);
                    end
                    if (hit) begin
                        r_found <= 1'b1;
                        r_state <= ST_RESOLVE;
                    end else if (issue_done && !r_pend) begin
                        r_state <= ST_RESOLVE;
                    end
                end
                ST_RESOLVE: begin
                    if (out_free) begin
                        r_out_loop  <= key_status.loop;
                        r_out_dup   <= n_dup;
                        r_out_drop  <= n_drop;
                        // The end of a graph empties the store.
                        if (r_last) begin
                            r_count   <= '0;
                            r_largest <= '0;
                        end else if (wr_en) begin
                            r_count <= r_count + CNT_W'(1);
                            if (key > r_largest) begin
                                r_largest <= key;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_out_drop, r_out_dup, r_out_loop};

    // Checks on the store bookkeeping and the result flags.
    `ELDD_ASSERT_SAME(a_count_bound, 1'b1, r_count <= DEPTH_C, "stored count above table depth")
    `ELDD_ASSERT_SAME(a_write_room, wr_en, r_count != DEPTH_C, "store written while full")
    `ELDD_ASSERT_SAME(a_flags_exclusive, r_out_valid, $onehot0(m_axis_tdata[2:0]), "flags clash")
    `ELDD_ASSERT_NEXT(a_accept_starts_key, in_accept, r_state == ST_KEY, "accept missed key stage")

endmodule
